// ===== hdl/ftam_pkg.sv =====
// Package: binary32 rounding helper functions, constants and types for the ternary unit.
package ftam_pkg;

    localparam int MODE_W = 2;
    localparam int FP_W = 32;
    localparam logic [FP_W-1:0] QNAN = 32'h7FC00000;
    localparam logic [FP_W-1:0] ONE = 32'h3F800000;
    localparam logic [FP_W-1:0] NEGZ = 32'h80000000;
    localparam int FMA_STAGES = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_REAL_ADDMUL = 2'd0,
        MODE_REAL_MULADD = 2'd1,
        MODE_CPLX_ADDMUL = 2'd2,
        MODE_CPLX_MULADD = 2'd3
    } t_mode;

    typedef struct packed {
        logic [FP_W-1:0] a_real;
        logic [FP_W-1:0] a_imag;
        logic [FP_W-1:0] b_real;
        logic [FP_W-1:0] b_imag;
        logic [FP_W-1:0] c_real;
        logic [FP_W-1:0] c_imag;
        logic            last_element;
    } t_in_item;

    typedef struct packed {
        logic [FP_W-1:0] r_real;
        logic [FP_W-1:0] r_imag;
        logic            last_result;
    } t_out_item;

    // Stage-1 record of an FMA: special-case result detected up front, plus signs, exponents and c mantissa.
    typedef struct packed {
        logic            spec;
        logic [FP_W-1:0] spec_val;
        logic            pz;      // product exact zero, c normal
        logic            sp;
        logic            sc;
        logic [9:0]      ep;      // biased sum ea+eb
        logic [7:0]      ec;
        logic [23:0]     mc;
        logic            cz;
    } t_fma_pre;

    function automatic logic [6:0] msb_pos(input logic [75:0] x);
        logic [6:0] p;
        p = 7'd0;
        for (int i = 0; i < 76; i++) begin
            if (x[i]) begin
                p = 7'(i);
            end
        end
        return p;
    endfunction

    // Round sign * m * 2^(e) where m has its leading one at p; be0 is the
    // biased exponent of bit 0 of m, so the result's biased exponent is be0+p.
    function automatic logic [FP_W-1:0] pack_round(input logic s, input logic [75:0] m,
                                                   input logic signed [11:0] be0);
        logic [6:0]         p;
        logic [75:0]        sh_m;
        logic [24:0]        mant;
        logic               g;
        logic               st;
        logic signed [11:0] be;
        p = msb_pos(m);
        sh_m = m << (7'd75 - p);
        mant = {1'b0, sh_m[75:52]};
        g = sh_m[51];
        st = |sh_m[50:0];
        if (g && (st || mant[0])) begin
            mant = mant + 25'd1;
        end
        be = be0 + 12'(signed'({5'd0, p}));
        if (mant[24]) begin
            be = be + 12'sd1;
        end
        if (be >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (be <= 12'sd0) begin
            return {s, 31'd0};
        end
        return {s, be[7:0], (mant[24] ? mant[23:1] : mant[22:0])};
    endfunction

endpackage

// ===== hdl/ftam_if.sv =====
// Valid/ready stream interface carrying one payload type.
interface ftam_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/ftam_fma.sv =====
// Pipelined binary32 fused multiply-add: classify, multiply, align/add, round.
module ftam_fma
    import ftam_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [FP_W-1:0] i_a,
    input  logic [FP_W-1:0] i_b,
    input  logic [FP_W-1:0] i_c,
    output logic [FP_W-1:0] o_r
);
    // stage 1: classify, multiply mantissas
    t_fma_pre    r_pre, n_pre;
    logic [47:0] r_pm;
    // stage 2: align and add
    t_fma_pre    r_pre2;
    logic [75:0] r_m;
    logic        r_rs;
    logic        r_zero;
    logic signed [11:0] r_be;
    // stage 3: round
    logic [FP_W-1:0] r_out;

    always_comb begin
        logic sa, sb, sc, ai, bi, ci, az, bz, cz, an, bn, cn;
        logic [7:0] ea, eb, ec;
        sa = i_a[31]; sb = i_b[31]; sc = i_c[31];
        ea = i_a[30:23]; eb = i_b[30:23]; ec = i_c[30:23];
        ai = ea == 8'hFF; bi = eb == 8'hFF; ci = ec == 8'hFF;
        az = ea == 8'd0; bz = eb == 8'd0; cz = ec == 8'd0;
        an = ai && (|i_a[22:0]); bn = bi && (|i_b[22:0]); cn = ci && (|i_c[22:0]);
        n_pre = '0;
        n_pre.sp = sa ^ sb;
        n_pre.sc = sc;
        n_pre.ep = {2'b0, ea} + {2'b0, eb};
        n_pre.ec = ec;
        n_pre.mc = {1'b1, i_c[22:0]};
        n_pre.cz = cz;
        if (an || bn || cn || (ai && bz) || (bi && az)) begin
            n_pre.spec = 1'b1; n_pre.spec_val = QNAN;
        end else if (ai || bi) begin
            n_pre.spec = 1'b1;
            n_pre.spec_val = (ci && sc != (sa ^ sb)) ? QNAN : {sa ^ sb, 8'hFF, 23'd0};
        end else if (ci) begin
            n_pre.spec = 1'b1; n_pre.spec_val = i_c;
        end else if (az || bz) begin
            n_pre.spec = 1'b1;
            n_pre.spec_val = cz ? (((sa ^ sb) == sc) ? {sc, 31'd0} : '0) : i_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
            r_pm <= {24'd0, 1'b1, i_a[22:0]} * {24'd0, 1'b1, i_b[22:0]};
        end
    end

    // Align: product bit 0 weight is 2^(ep-127-127-46); place product with
    // 26 guard bits (bits 73..26), c at bits 49..26 shifted by exponent diff.
    always_ff @(posedge i_clk) begin
        logic signed [11:0] ep_u, ec_u, d;
        logic [75:0] pmw, cmw, cs;
        logic        stk;
        if (i_en) begin
            r_pre2 <= r_pre;
            // exponent of bit 0 of the extended word: ep-254-46-26 (unbiased)
            ep_u = 12'(signed'({2'b0, r_pre.ep})) - 12'sd326;
            // c mantissa placed at bits 49..26 => bit 26 exponent ec-150; align to same
            // write c as cm << 26 with bit-0 exponent ec-127-23-26 = ec-176
            ec_u = 12'(signed'({4'b0, r_pre.ec})) - 12'sd176;
            pmw = {2'b0, r_pm, 26'd0};
            cmw = {26'd0, r_pre.mc, 26'd0};
            d = ep_u - ec_u;
            if (r_pre.cz) begin
                r_m <= pmw; r_rs <= r_pre.sp; r_zero <= 1'b0;
                r_be <= ep_u + 12'sd150 - 12'sd23;
            end else if (d >= 12'sd0) begin
                // c smaller: shift c right
                if (d >= 12'sd76) begin
                    cs = 76'(|cmw);
                end else begin
                    stk = |(cmw & ((76'd1 << d[6:0]) - 76'd1));
                    cs = (cmw >> d[6:0]) | 76'(stk);
                end
                r_be <= ep_u + 12'sd150 - 12'sd23;
                if (r_pre.sp == r_pre.sc) begin
                    r_m <= pmw + cs; r_rs <= r_pre.sp; r_zero <= 1'b0;
                end else if (pmw > cs) begin
                    r_m <= pmw - cs; r_rs <= r_pre.sp; r_zero <= 1'b0;
                end else begin
                    r_m <= cs - pmw; r_rs <= r_pre.sc; r_zero <= (cs == pmw);
                end
            end else begin
                if (-d >= 12'sd76) begin
                    cs = 76'(|pmw);
                end else begin
                    stk = |(pmw & ((76'd1 << 7'(-d)) - 76'd1));
                    cs = (pmw >> 7'(-d)) | 76'(stk);
                end
                r_be <= ec_u + 12'sd150 - 12'sd23;
                if (r_pre.sp == r_pre.sc) begin
                    r_m <= cs + cmw; r_rs <= r_pre.sp; r_zero <= 1'b0;
                end else if (cs > cmw) begin
                    r_m <= cs - cmw; r_rs <= r_pre.sp; r_zero <= 1'b0;
                end else begin
                    r_m <= cmw - cs; r_rs <= r_pre.sc; r_zero <= (cs == cmw);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_pre2.spec) begin
                r_out <= r_pre2.spec_val;
            end else if (r_zero) begin
                r_out <= '0;
            end else begin
                r_out <= pack_round(r_rs, r_m, r_be);
            end
        end
    end

    assign o_r = r_out;
endmodule

// ===== hdl/ftam_datapath.sv =====
// Three rows of FMA units that chain the ternary operations of all four modes.
module ftam_datapath
    import ftam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en,
    input  t_mode    i_mode,
    input  t_in_item i_item,
    output t_out_item o_item
);
    localparam int STAGES = FMA_STAGES;

    // side pipeline alongside each FMA row
    t_mode    r_md1 [STAGES];
    t_in_item r_it1 [STAGES];
    t_mode    r_md2 [STAGES];
    t_in_item r_it2 [STAGES];
    logic [FP_W-1:0] r1_0, r1_1, r2_0, r2_1, r3_0, r3_1;
    logic [FP_W-1:0] a1_0, b1_0, c1_0, a1_1, b1_1, c1_1;
    logic [FP_W-1:0] a2_0, b2_0, c2_0, a2_1, b2_1, c2_1;
    logic [FP_W-1:0] a3_0, b3_0, c3_0, a3_1, b3_1, c3_1;
    t_mode    m1, m2;
    t_in_item t1, t2;

    // Row 1: sums (mode 0,2) or first fused step (1,3)
    always_comb begin
        unique case (i_mode)
            MODE_REAL_ADDMUL, MODE_CPLX_ADDMUL: begin
                a1_0 = i_item.a_real; b1_0 = ONE; c1_0 = i_item.b_real;
                a1_1 = i_item.a_imag; b1_1 = ONE; c1_1 = i_item.b_imag;
            end
            MODE_REAL_MULADD: begin
                a1_0 = i_item.a_real; b1_0 = i_item.b_real; c1_0 = i_item.c_real;
                a1_1 = '0; b1_1 = '0; c1_1 = '0;
            end
            default: begin
                a1_0 = i_item.a_real; b1_0 = i_item.b_real; c1_0 = i_item.c_real;
                a1_1 = i_item.a_real; b1_1 = i_item.b_imag; c1_1 = i_item.c_imag;
            end
        endcase
    end

    ftam_fma u_f1_0 (.i_clk, .i_en, .i_a(a1_0), .i_b(b1_0), .i_c(c1_0), .o_r(r1_0));
    ftam_fma u_f1_1 (.i_clk, .i_en, .i_a(a1_1), .i_b(b1_1), .i_c(c1_1), .o_r(r1_1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_md1[0] <= i_mode; r_it1[0] <= i_item;
            for (int i = 1; i < STAGES; i++) begin
                r_md1[i] <= r_md1[i-1]; r_it1[i] <= r_it1[i-1];
            end
        end
    end
    assign m1 = r_md1[STAGES-1];
    assign t1 = r_it1[STAGES-1];

    // Row 2: products of the real sum (mode 0,2), the chained step (mode 3), or pass-through (mode 1)
    always_comb begin
        unique case (m1)
            MODE_CPLX_MULADD: begin
                a2_0 = {~t1.a_imag[31], t1.a_imag[30:0]}; b2_0 = t1.b_imag; c2_0 = r1_0;
                a2_1 = t1.a_imag; b2_1 = t1.b_real; c2_1 = r1_1;
            end
            MODE_REAL_MULADD: begin
                a2_0 = r1_0; b2_0 = ONE; c2_0 = NEGZ;
                a2_1 = '0; b2_1 = '0; c2_1 = '0;
            end
            default: begin
                a2_0 = r1_0; b2_0 = t1.c_real; c2_0 = NEGZ;
                a2_1 = r1_0; b2_1 = t1.c_imag; c2_1 = NEGZ;
            end
        endcase
    end

    ftam_fma u_f2_0 (.i_clk, .i_en, .i_a(a2_0), .i_b(b2_0), .i_c(c2_0), .o_r(r2_0));
    ftam_fma u_f2_1 (.i_clk, .i_en, .i_a(a2_1), .i_b(b2_1), .i_c(c2_1), .o_r(r2_1));

    logic [FP_W-1:0] r_ti [STAGES];
    logic [FP_W-1:0] r_rm1 [STAGES];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_md2[0] <= m1; r_it2[0] <= t1; r_ti[0] <= r1_1; r_rm1[0] <= r1_0;
            for (int i = 1; i < STAGES; i++) begin
                r_md2[i] <= r_md2[i-1]; r_it2[i] <= r_it2[i-1];
                r_ti[i] <= r_ti[i-1]; r_rm1[i] <= r_rm1[i-1];
            end
        end
    end
    assign m2 = r_md2[STAGES-1];
    assign t2 = r_it2[STAGES-1];

    // Row 3: complex add-mul cross terms; other modes feed zeros and bypass this row
    always_comb begin
        logic [FP_W-1:0] ti;
        ti = r_ti[STAGES-1];
        unique case (m2)
            MODE_CPLX_ADDMUL: begin
                a3_0 = {~ti[31], ti[30:0]}; b3_0 = t2.c_imag; c3_0 = r2_0;
                a3_1 = ti; b3_1 = t2.c_real; c3_1 = r2_1;
            end
            default: begin
                a3_0 = '0; b3_0 = '0; c3_0 = '0;
                a3_1 = '0; b3_1 = '0; c3_1 = '0;
            end
        endcase
    end

    ftam_fma u_f3_0 (.i_clk, .i_en, .i_a(a3_0), .i_b(b3_0), .i_c(c3_0), .o_r(r3_0));
    ftam_fma u_f3_1 (.i_clk, .i_en, .i_a(a3_1), .i_b(b3_1), .i_c(c3_1), .o_r(r3_1));

    t_mode    r_md3 [STAGES];
    logic     r_l3 [STAGES];
    logic [FP_W-1:0] r_p0 [STAGES];
    logic [FP_W-1:0] r_p1 [STAGES];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_md3[0] <= m2; r_l3[0] <= t2.last_element;
            r_p0[0] <= (m2 == MODE_REAL_MULADD) ? r_rm1[STAGES-1] : r2_0;
            r_p1[0] <= r2_1;
            for (int i = 1; i < STAGES; i++) begin
                r_md3[i] <= r_md3[i-1]; r_l3[i] <= r_l3[i-1];
                r_p0[i] <= r_p0[i-1]; r_p1[i] <= r_p1[i-1];
            end
        end
    end

    always_comb begin
        o_item.last_result = r_l3[STAGES-1];
        unique case (r_md3[STAGES-1])
            MODE_CPLX_ADDMUL: begin
                o_item.r_real = r3_0; o_item.r_imag = r3_1;
            end
            MODE_CPLX_MULADD: begin
                o_item.r_real = r_p0[STAGES-1]; o_item.r_imag = r_p1[STAGES-1];
            end
            default: begin
                o_item.r_real = r_p0[STAGES-1]; o_item.r_imag = '0;
            end
        endcase
    end
endmodule

// ===== hdl/fp32_ternary_add_mul_unit_core.sv =====
// Top level of the binary32 ternary add/multiply unit with stream handshake.
// The unit takes one transaction per cycle unless the output stalls and
// returns one result per transaction, in order, through three rows of
// FMA units, each FMA_STAGES (3) register stages deep (classify and
// multiply, align and add, normalize and round). Throughput is one
// transaction per cycle unless stalled, set by the fully pipelined FMA
// rows. The whole pipeline advances together when the last stage is
// empty or being taken; a stall freezes it with valid bits
// in place, so nothing is lost or repeated. The mode register is written
// through i_cfg_we/i_cfg_data and must only change while idle.
// Mode 0 real (a+b)*c, 1 real fused a*b+c, 2 complex (a+b)*c, 3 complex a*b+c;
// round to nearest even, subnormals flush to zero, NaN results are 0x7FC00000.
module fp32_ternary_add_mul_unit_core
    import ftam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    ftam_if.sink              i_in,
    ftam_if.source            o_out
);
    localparam int LAT = 3 * FMA_STAGES;

    logic  r_mode;
    t_mode r_mode_q;
    logic  [LAT-1:0] r_vld;
    logic  w_en;
    t_out_item w_res;

    // Hold the mode register; reset to real add-mul.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_q <= MODE_REAL_ADDMUL;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode_q <= t_mode'(i_cfg_data);
            r_mode <= 1'b1;
        end
    end

    // Advance whenever the last stage is empty or being taken.
    assign w_en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    ftam_datapath u_dp (
        .i_clk,
        .i_en  (w_en),
        .i_mode(r_mode_q),
        .i_item(i_in.data),
        .o_item(w_res)
    );

    assign o_out.valid = r_vld[LAT-1];
    assign o_out.data = w_res;

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result changed under stall");
    // An accepted input must show up in the first pipeline valid bit.
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transaction lost");
    // Mode flag tracks a write.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_mode)
        else $error("mode write lost");
endmodule

// ===== bench/tb_fp32_ternary_add_mul_unit_core.sv =====
// Testbench for the binary32 ternary add/multiply unit: bit-exact predictor, scoreboard, random traffic.
module tb_fp32_ternary_add_mul_unit_core;
    import ftam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 430;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;

    // Scoreboard: predicts each result as its input is accepted and compares outputs in order.
    class fma_scoreboard;
        t_mode     mode;
        t_out_item pending[$];
        int        errors;

        function new();
            mode = MODE_REAL_ADDMUL;
            errors = 0;
        endfunction

        // Position of the leading one, -1 for zero.
        function automatic int lead_one(logic [63:0] x);
            int p;
            p = -1;
            for (int i = 0; i < 64; i++) begin
                if (x[i]) p = i;
            end
            return p;
        endfunction

        // Shift right and fold the lost bits into the lowest bit.
        function automatic logic [63:0] shift_sticky(logic [63:0] x, int d);
            logic [63:0] r;
            if (d <= 0) return x;
            if (d >= 64) return (x != 0) ? 64'd1 : 64'd0;
            r = x >> d;
            if ((x & ((64'd1 << d) - 1)) != 0) r[0] = 1'b1;
            return r;
        endfunction

        // Round s * m * 2^e to nearest even; flush tiny, saturate to infinity.
        function automatic logic [31:0] round_pack(logic s, logic [63:0] m, int e);
            int          p;
            int          sh;
            int          bexp;
            logic [63:0] mant;
            logic [63:0] rem;
            logic [63:0] half;
            p = lead_one(m);
            if (p < 23) begin
                mant = m << (23 - p);
            end else begin
                sh = p - 23;
                mant = m >> sh;
                if (sh > 0) begin
                    rem = m & ((64'd1 << sh) - 1);
                    half = 64'd1 << (sh - 1);
                    if (rem > half || (rem == half && mant[0])) mant = mant + 1;
                end
            end
            bexp = e + p - 23 + 150;
            if (mant >= (64'd1 << 24)) begin
                mant = mant >> 1;
                bexp++;
            end
            if (bexp >= 255) return {s, 8'hFF, 23'd0};
            if (bexp <= 0) return {s, 31'd0};
            return {s, bexp[7:0], mant[22:0]};
        endfunction

        // Fused multiply-add, single rounding.
        function automatic logic [31:0] fused(logic [31:0] a, logic [31:0] b, logic [31:0] c);
            logic        sp;
            logic        rs;
            int          ea, eb, ec, ep, ecx, sh;
            logic [63:0] pm, cm, m;
            bit          ai, bi, ci, az, bz, cz;
            sp = a[31] ^ b[31];
            ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
            ai = ea == 255; bi = eb == 255; ci = ec == 255;
            az = ea == 0; bz = eb == 0; cz = ec == 0;
            if ((ai && a[22:0] != 0) || (bi && b[22:0] != 0) || (ci && c[22:0] != 0))
                return QNAN;
            if ((ai && bz) || (bi && az)) return QNAN;
            if (ai || bi) begin
                if (ci && c[31] != sp) return QNAN;
                return {sp, 8'hFF, 23'd0};
            end
            if (ci) return c;
            if (az || bz) begin
                if (cz) return (sp == c[31]) ? {sp, 31'd0} : 32'd0;
                return c;
            end
            pm = {40'd0, 1'b1, a[22:0]} * {40'd0, 1'b1, b[22:0]};
            ep = ea + eb - 300;
            sh = 61 - lead_one(pm);
            pm = pm << sh;
            ep = ep - sh;
            if (cz) return round_pack(sp, pm, ep);
            cm = {40'd0, 1'b1, c[22:0]} << 38;
            ecx = ec - 188;
            if (ep >= ecx) begin
                cm = shift_sticky(cm, ep - ecx);
            end else begin
                pm = shift_sticky(pm, ecx - ep);
                ep = ecx;
            end
            if (sp == c[31]) begin
                m = pm + cm; rs = sp;
            end else if (pm > cm) begin
                m = pm - cm; rs = sp;
            end else if (cm > pm) begin
                m = cm - pm; rs = c[31];
            end else begin
                return 32'd0;
            end
            return round_pack(rs, m, ep);
        endfunction

        function automatic t_out_item compute(t_in_item x);
            t_out_item   r;
            logic [31:0] tr, ti, sv, tv;
            r = '0;
            r.last_result = x.last_element;
            case (mode)
                MODE_REAL_ADDMUL: begin
                    r.r_real = fused(fused(x.a_real, ONE, x.b_real), x.c_real, NEGZ);
                end
                MODE_REAL_MULADD: begin
                    r.r_real = fused(x.a_real, x.b_real, x.c_real);
                end
                MODE_CPLX_ADDMUL: begin
                    tr = fused(x.a_real, ONE, x.b_real);
                    ti = fused(x.a_imag, ONE, x.b_imag);
                    sv = fused(tr, x.c_real, NEGZ);
                    tv = fused(tr, x.c_imag, NEGZ);
                    r.r_real = fused(ti ^ NEGZ, x.c_imag, sv);
                    r.r_imag = fused(ti, x.c_real, tv);
                end
                default: begin
                    r.r_real = fused(x.a_imag ^ NEGZ, x.b_imag,
                                     fused(x.a_real, x.b_real, x.c_real));
                    r.r_imag = fused(x.a_imag, x.b_real,
                                     fused(x.a_real, x.b_imag, x.c_imag));
                end
            endcase
            return r;
        endfunction

        function void note_input(t_in_item x);
            pending.push_back(compute(x));
        endfunction

        task automatic report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task automatic check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report("unexpected result", got.r_real, 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.r_real !== want.r_real) report("r_real", got.r_real, want.r_real);
            if (got.r_imag !== want.r_imag) report("r_imag", got.r_imag, want.r_imag);
            if (got.last_result !== want.last_result)
                report("last_result", 32'(got.last_result), 32'(want.last_result));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MODE_W-1:0] i_cfg_data;

    ftam_if #(.T(t_in_item))  in_ch();
    ftam_if #(.T(t_out_item)) out_ch();

    fp32_ternary_add_mul_unit_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    fma_scoreboard sb = new();
    int  quiet_cycles;
    bit  eager;          // when set, neither side idles
    bit  sending_done;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watch both channels: note inputs, check outputs, and count idle cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (sending_done && sb.pending.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if traffic stops for too long.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sink side: drop ready about 23 percent of the time unless eager.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= eager || ($urandom_range(99) >= 23);
    end

    // Pick a binary32 pattern biased toward special values and nearby exponents.
    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        int          k;
        v = $urandom;
        k = $urandom_range(99);
        if (k < 8) begin
            v[30:23] = 8'hFF;
            if ($urandom_range(1)) v[22:0] = '0;
        end else if (k < 16) begin
            v[30:23] = 8'h00;
            if ($urandom_range(1)) v[22:0] = '0;
        end else if (k < 22) begin
            v[30:23] = $urandom_range(1) ? 8'hFE : 8'h01;
        end else if (k < 80) begin
            v[30:23] = 8'(120 + $urandom_range(14));
        end
        return v;
    endfunction

    // Present one transaction and hold it until accepted, with random idle gaps.
    task automatic send_item(t_in_item x);
        while (!eager && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= x;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_fields(logic [31:0] ar, logic [31:0] br, logic [31:0] cr,
                               logic [31:0] ai, logic [31:0] bi, logic [31:0] ci,
                               logic last);
        t_in_item x;
        x.a_real = ar; x.b_real = br; x.c_real = cr;
        x.a_imag = ai; x.b_imag = bi; x.c_imag = ci;
        x.last_element = last;
        send_item(x);
    endtask

    task automatic send_random();
        send_fields(rand_fp(), rand_fp(), rand_fp(), rand_fp(), rand_fp(), rand_fp(),
                    1'($urandom_range(1)));
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.mode = m;
    endtask

    initial begin
        t_mode m;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        eager        = 1'b0;
        sending_done = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes and special cases across all modes.
        for (int md = 0; md < 4; md++) begin
            m = t_mode'(md);
            write_mode(m);
            send_fields(32'h3F800000, 32'h40000000, 32'h40400000,
                        32'h3F800000, 32'hBF000000, 32'h40000000, 1'b0);
            send_fields(32'hFFFFFFFF, 32'h00000000, 32'h7F800000,
                        32'hFFFFFFFF, 32'h7FFFFFFF, 32'h00000000, 1'b1);
            send_fields(32'h7F800000, 32'h00000000, 32'h3F800000,
                        32'h7F800000, 32'hFF800000, 32'h00000001, 1'b0);
            send_fields(32'h7F7FFFFF, 32'h7F7FFFFF, 32'h40000000,
                        32'h7F7FFFFF, 32'h7F7FFFFF, 32'hC0000000, 1'b1);
            send_fields(32'h3F800000, 32'hBF800000, 32'h80000000,
                        32'h00800000, 32'h80800000, 32'h007FFFFF, 1'b0);
            send_fields(32'h00800000, 32'h3F000000, 32'h80800000,
                        32'h80000000, 32'h80000000, 32'h00800000, 1'b1);
            drain();
        end

        // Random part: modes cycle through the range, one phase without idling.
        for (int ph = 0; ph < 6; ph++) begin
            m = t_mode'(ph == 5 ? 3 : $urandom_range(3));
            if (ph < 4) m = t_mode'(ph);
            write_mode(m);
            eager = (ph == 2);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                send_random();
                // Hold off mid-phase until all results are back.
                if (i == 20) drain();
            end
            eager = 1'b0;
            drain();
        end

        sending_done = 1'b1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
